FILE: src/btha_pkg.sv
// ============================================================================
// btha_pkg: shared types and constants for the block table heap allocator
// Block geometry, flag layout, status codes and controller/datapath links.
// ============================================================================
package btha_pkg;

  localparam int ADDR_W         = 32;
  localparam int BLOCK_BYTES    = 4096;              // power of two
  localparam int OFF_W          = $clog2(BLOCK_BYTES);
  localparam int DEF_MAX_BLOCKS = 1024;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int BIU_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;

  // Table entry flags
  localparam int FLAG_W  = 3;
  localparam int F_TAKEN = 0;
  localparam int F_FIRST = 1;
  localparam int F_NEXT  = 2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic    clear;
    logic    accept;
    logic    scan;
    logic    mark;
    logic    free_step;
    logic    report;
    logic    rpt_addr;
    status_t rpt_status;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic req_free;
    logic req_bad;
    logic req_no_room;
    logic found;
    logic scan_end;
    logic mark_last;
    logic free_last;
  } sts_t;

endpackage

FILE: src/block_table_heap_allocator.sv
// ============================================================================
// block_table_heap_allocator: first-fit allocator over a block flag table
// Allocates runs of fixed-size blocks by byte count and frees them by address.
// ============================================================================
// Usage:
//   Input channel: present in_action / in_request_bytes / in_free_address and
//   raise start; the item is taken at the edge where start is high and busy
//   is low. One result item follows per request on out_block_address /
//   out_status, marked by out_valid for exactly one cycle; the receiver
//   cannot stall it, so capture it when out_valid is high.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 heap
//   base, 1 blocks in use) at the same edge; write only while busy is low.
//   A rejected request is answered in the cycle after the edge that takes it.
//   An allocate walks the table from entry 0 until a free run of the needed
//   length ends, then marks that run; it answers no room when none fits. A
//   free walks the run from its first entry and clears it. busy falls as
//   out_valid rises, so the next item can be taken at the edge that takes the
//   result. The table walk runs at one entry per cycle through the single
//   read port of the flag memory.
//   Reset: the flag table is cleared by a pass over all MAX_BLOCKS entries,
//   one entry per cycle; busy stays high until it ends. Registers reset to
//   base 0 and 1024 blocks in use.
// ============================================================================
module block_table_heap_allocator #(
  parameter int MAX_BLOCKS = btha_pkg::DEF_MAX_BLOCKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [btha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btha_pkg::CFG_W-1:0]       cfg_wdata,
  // request item
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_action,
  input  logic [btha_pkg::ADDR_W-1:0]      in_request_bytes,
  input  logic [btha_pkg::ADDR_W-1:0]      in_free_address,
  // result item
  output logic                             out_valid,
  output logic [btha_pkg::ADDR_W-1:0]      out_block_address,
  output logic [1:0]                       out_status
);

  logic [btha_pkg::ADDR_W-1:0] heap_base_r;
  logic [btha_pkg::BIU_W-1:0]  blocks_in_use_r;

  btha_pkg::cmd_t cmd;
  btha_pkg::sts_t sts;

  // Hold configuration; writes land at once, no handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r     <= '0;
      blocks_in_use_r <= btha_pkg::BIU_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        btha_pkg::CFG_HEAP_BASE: begin
          heap_base_r <= cfg_wdata[btha_pkg::ADDR_W-1:0];
        end
        btha_pkg::CFG_BLOCKS_IN_USE: begin
          blocks_in_use_r <= cfg_wdata[btha_pkg::BIU_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: clear pass, request check, scan / mark / free phases
  btha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Flag table, walk pointer and result registers
  btha_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .heap_base         (heap_base_r),
    .blocks_in_use     (blocks_in_use_r),
    .in_action         (in_action),
    .in_request_bytes  (in_request_bytes),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_block_address (out_block_address),
    .out_status        (out_status)
  );

  // An accepted item either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither processed nor answered");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == btha_pkg::ST_OK || out_status == btha_pkg::ST_NO_ROOM ||
                   out_status == btha_pkg::ST_INVALID))
    else $error("undefined status code");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != btha_pkg::ST_OK) |-> (out_block_address == '0))
    else $error("failed request returned an address");

endmodule

FILE: src/btha_ctrl.sv
// ============================================================================
// btha_ctrl: sequencing state machine
// Steps through table clear, request check, scan, mark and free phases.
// ============================================================================
module btha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  btha_pkg::sts_t  sts,
  output btha_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rpt_status = btha_pkg::ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.req_bad) begin
            cmd.report     = 1'b1;
            cmd.rpt_status = btha_pkg::ST_INVALID;
          end else if (sts.req_no_room) begin
            cmd.report     = 1'b1;
            cmd.rpt_status = btha_pkg::ST_NO_ROOM;
          end else if (sts.req_free) begin
            state_nxt = S_FREE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_nxt = S_MARK;
        end else if (sts.scan_end) begin
          cmd.report     = 1'b1;
          cmd.rpt_status = btha_pkg::ST_NO_ROOM;
          state_nxt      = S_IDLE;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          cmd.report   = 1'b1;
          cmd.rpt_addr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FREE: begin
        cmd.free_step = 1'b1;
        if (sts.free_last) begin
          cmd.report = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

FILE: src/btha_datapath.sv
// ============================================================================
// btha_datapath: block table memory, pointers and result registers
// Holds the flag table, the scan/mark/free pointer and the result item.
// ============================================================================
module btha_datapath #(
  parameter int MAX_BLOCKS = btha_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btha_pkg::cmd_t                cmd,
  output btha_pkg::sts_t                sts,
  input  logic [btha_pkg::ADDR_W-1:0]   heap_base,
  input  logic [btha_pkg::BIU_W-1:0]    blocks_in_use,
  input  logic                          in_action,
  input  logic [btha_pkg::ADDR_W-1:0]   in_request_bytes,
  input  logic [btha_pkg::ADDR_W-1:0]   in_free_address,
  output logic                          out_valid,
  output logic [btha_pkg::ADDR_W-1:0]   out_block_address,
  output logic [1:0]                    out_status
);

  localparam int ADDR_W = btha_pkg::ADDR_W;
  localparam int OFF_W  = btha_pkg::OFF_W;
  localparam int FLAG_W = btha_pkg::FLAG_W;
  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int NEED_W = ADDR_W + 1 - OFF_W;
  localparam int BIX_W  = ADDR_W - OFF_W;

  logic [FLAG_W-1:0] mem [MAX_BLOCKS];
  logic [FLAG_W-1:0] rdata_r;

  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] pidx_r;
  logic             vld_r, vld_nxt;

  logic                  out_valid_r;
  logic [ADDR_W-1:0]     out_addr_r;
  btha_pkg::status_t     out_status_r;

  // Configuration view
  logic [ADDR_W-1:0] base_al;
  logic [ADDR_W-1:0] biu_ext;
  logic [CNT_W-1:0]  n_blk;

  assign base_al = {heap_base[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
  assign biu_ext = ADDR_W'(blocks_in_use);
  assign n_blk   = (biu_ext > ADDR_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                    : biu_ext[CNT_W-1:0];

  // Request check
  logic [ADDR_W:0]   round_sum;
  logic [NEED_W-1:0] need_full;
  logic [ADDR_W-1:0] diff;
  logic [BIX_W-1:0]  idx_full;
  logic              alloc_zero, alloc_big, free_low, free_high;

  assign round_sum  = {1'b0, in_request_bytes} + (ADDR_W+1)'(btha_pkg::BLOCK_BYTES - 1);
  assign need_full  = round_sum[ADDR_W:OFF_W];
  assign diff       = in_free_address - base_al;
  assign idx_full   = diff[ADDR_W-1:OFF_W];
  assign alloc_zero = (in_request_bytes == '0);
  assign alloc_big  = (need_full > NEED_W'(n_blk));
  assign free_low   = (in_free_address < base_al);
  assign free_high  = (ADDR_W'(idx_full) >= ADDR_W'(n_blk));

  // Scan, mark and free status
  logic              issue, taken;
  logic [CNT_W-1:0]  run_inc, pidx_inc, mark_last_idx;
  logic [IDX_W-1:0]  run_start;

  assign issue         = (ptr_r < n_blk);
  assign taken         = rdata_r[btha_pkg::F_TAKEN];
  assign run_inc       = run_r + 1'b1;
  assign run_start     = (run_r == '0) ? pidx_r : start_r;
  assign pidx_inc      = CNT_W'(pidx_r) + 1'b1;
  assign mark_last_idx = CNT_W'(start_r) + need_r - 1'b1;

  assign sts.clear_last  = (ptr_r == CNT_W'(MAX_BLOCKS - 1));
  assign sts.req_free    = in_action;
  assign sts.req_bad     = in_action ? (free_low || free_high) : alloc_zero;
  assign sts.req_no_room = !in_action && alloc_big;
  assign sts.found       = vld_r && !taken && (run_inc == need_r);
  assign sts.scan_end    = !vld_r && !issue;
  assign sts.mark_last   = (ptr_r == mark_last_idx);
  assign sts.free_last   = vld_r && (!rdata_r[btha_pkg::F_NEXT] || pidx_inc == n_blk);

  always_comb begin
    ptr_nxt   = ptr_r;
    run_nxt   = run_r;
    start_nxt = start_r;
    need_nxt  = need_r;
    vld_nxt   = 1'b0;
    if (cmd.accept) begin
      ptr_nxt  = in_action ? CNT_W'(idx_full) : '0;
      need_nxt = CNT_W'(need_full);
      run_nxt  = '0;
    end else if (cmd.clear || cmd.mark) begin
      ptr_nxt = ptr_r + 1'b1;
    end else if (cmd.scan) begin
      if (sts.found) begin
        // jump back to the run start for marking
        ptr_nxt   = CNT_W'(run_start);
        start_nxt = run_start;
      end else begin
        if (issue) begin
          ptr_nxt = ptr_r + 1'b1;
          vld_nxt = 1'b1;
        end
        if (vld_r) begin
          if (taken) begin
            run_nxt = '0;
          end else begin
            start_nxt = run_start;
            run_nxt   = run_inc;
          end
        end
      end
    end else if (cmd.free_step) begin
      ptr_nxt = ptr_r + 1'b1;
      vld_nxt = 1'b1;
    end
  end

  // Table write port
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [FLAG_W-1:0] mem_wdata;
  logic [FLAG_W-1:0] mark_flags;

  always_comb begin
    mark_flags                     = '0;
    mark_flags[btha_pkg::F_TAKEN]  = 1'b1;
    mark_flags[btha_pkg::F_FIRST]  = (ptr_r == CNT_W'(start_r));
    mark_flags[btha_pkg::F_NEXT]   = !sts.mark_last;
  end

  assign mem_we    = cmd.clear || cmd.mark || (cmd.free_step && vld_r);
  assign mem_waddr = cmd.free_step ? pidx_r : ptr_r[IDX_W-1:0];
  assign mem_wdata = cmd.mark ? mark_flags : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[ptr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    run_r   <= run_nxt;
    need_r  <= need_nxt;
    start_r <= start_nxt;
    pidx_r  <= ptr_r[IDX_W-1:0];
    if (cmd.report) begin
      out_addr_r   <= cmd.rpt_addr ? base_al + (ADDR_W'(start_r) << OFF_W) : '0;
      out_status_r <= cmd.rpt_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_addr_r;
  assign out_status        = out_status_r;

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> (ptr_r < n_blk))
    else $error("mark beyond managed blocks");

  a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.free_step && vld_r) |-> (CNT_W'(pidx_r) < n_blk))
    else $error("free clears beyond managed blocks");

endmodule
